/* sv/dsspr_pkg.sv */
// Shared types and constants for the two-stack swap/push/rotate engine.
// Used by the engine and the port checker.
package dsspr_pkg;

  // Item field widths
  localparam int FUNC_W  = 4;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 10;

  // Packed stream widths, padded to whole bytes
  localparam int S_DATA_W = 40;  // func, load_value
  localparam int M_DATA_W = 88;  // performed, rejected_full, count_a, count_b, top_a, top_b

  // Command codes
  typedef enum logic [FUNC_W-1:0] {
    F_LOAD  = 4'd0,
    F_SA    = 4'd1,
    F_SB    = 4'd2,
    F_SS    = 4'd3,
    F_PA    = 4'd4,
    F_PB    = 4'd5,
    F_RA    = 4'd6,
    F_RB    = 4'd7,
    F_RR    = 4'd8,
    F_RRA   = 4'd9,
    F_RRB   = 4'd10,
    F_RRR   = 4'd11,
    F_CLEAR = 4'd12
  } func_t;

  // Per-stack view of a command
  typedef struct packed {
    logic swap;
    logic rot_up;
    logic rot_dn;
  } stk_op_t;

  // Work out what a command does to stack A (side_b low) or stack B
  function automatic stk_op_t stk_decode(func_t f, logic side_b);
    stk_op_t op;
    if (side_b) begin
      op.swap   = (f == F_SB)  || (f == F_SS);
      op.rot_up = (f == F_RB)  || (f == F_RR);
      op.rot_dn = (f == F_RRB) || (f == F_RRR);
    end else begin
      op.swap   = (f == F_SA)  || (f == F_SS);
      op.rot_up = (f == F_RA)  || (f == F_RR);
      op.rot_dn = (f == F_RRA) || (f == F_RRR);
    end
    return op;
  endfunction

endpackage

/* sv/dual_stack_swap_push_rotate_engine.sv */
// Two-stack swap/push/rotate engine: sequencer, pointers and stack memories.
// Depends on dsspr_pkg and dsspr_ram.
//
// One command is in flight at a time. A command goes through these steps:
// read operand at acceptance, write back, read both tops, load the result
// register. Swap commands (sa, sb, ss) also read the second entry after the
// operand and write the old top one down after the write back, because both
// top entries go through the single read port and single write port of each
// stack memory one after the other. A finished result sits in an output
// register, and the next command is taken while it waits; a second finished
// result waits in the sequencer and stalls the input until the first is taken.
// Stacks A and B each live in their own CAPACITY-word RAM, so a command on both
// stacks (ss, rr, rrr) works on them in parallel.
module dual_stack_swap_push_rotate_engine #(
  parameter int CAPACITY = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  // s_tdata: [3:0] func, [35:4] load_value, [39:36] zero
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [dsspr_pkg::S_DATA_W-1:0]  s_tdata,
  // m_tdata: [0] performed, [1] rejected_full, [11:2] count_a, [21:12] count_b,
  //          [53:22] top_a, [85:54] top_b, [87:86] zero
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [dsspr_pkg::M_DATA_W-1:0]  m_tdata
);

  import dsspr_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD1,
    ST_WR0,
    ST_WR1,
    ST_TOP,
    ST_OUT
  } state_t;

  // (h + k) mod CAPACITY, with h < CAPACITY and k <= CAPACITY
  function automatic logic [AW-1:0] wrap_sum(logic [AW-1:0] h, logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(k);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return AW'(s);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(logic [AW-1:0] h);
    return (h == '0) ? AW'(CAPACITY - 1) : h - AW'(1);
  endfunction

  state_t                     state;
  func_t                      cmd;
  logic signed [WORD_W-1:0]   load_val;
  logic [AW-1:0]              head_a, head_b;
  logic [CW-1:0]              fill_a, fill_b;
  logic [WORD_W-1:0]          d0_a, d0_b;
  logic                       perf, rej;

  logic                       out_perf, out_rej;
  logic [COUNT_W-1:0]         out_cnt_a, out_cnt_b;
  logic signed [WORD_W-1:0]   out_top_a, out_top_b;

  // Memory ports
  logic               we_a, we_b, re_a, re_b;
  logic [AW-1:0]      waddr_a, waddr_b, raddr_a, raddr_b;
  logic [WORD_W-1:0]  wdata_a, wdata_b, rdata_a, rdata_b;

  func_t              in_func;
  stk_op_t            in_op_a, in_op_b, op_a, op_b;
  logic [AW-1:0]      inc_a, inc_b, dec_a, dec_b, tail_a, tail_b, bot_a, bot_b;
  logic               room;

  assign in_func = func_t'(s_tdata[FUNC_W-1:0]);
  assign in_op_a = stk_decode(in_func, 1'b0);
  assign in_op_b = stk_decode(in_func, 1'b1);
  assign op_a    = stk_decode(cmd, 1'b0);
  assign op_b    = stk_decode(cmd, 1'b1);

  // Neighbouring positions of each stack
  assign inc_a  = wrap_sum(head_a, CW'(1));
  assign inc_b  = wrap_sum(head_b, CW'(1));
  assign dec_a  = wrap_dec(head_a);
  assign dec_b  = wrap_dec(head_b);
  assign tail_a = wrap_sum(head_a, fill_a);
  assign tail_b = wrap_sum(head_b, fill_b);
  assign bot_a  = wrap_sum(dec_a, fill_a);
  assign bot_b  = wrap_sum(dec_b, fill_b);
  assign room   = (SW'(fill_a) + SW'(fill_b)) < SW'(CAPACITY);

  assign s_tready = (state == ST_IDLE);

  assign m_tdata = {2'b00, out_top_b, out_top_a, out_cnt_b, out_cnt_a, out_rej, out_perf};

  // Memory access per sequencer step
  always_comb begin
    we_a    = 1'b0;
    we_b    = 1'b0;
    re_a    = 1'b0;
    re_b    = 1'b0;
    waddr_a = head_a;
    waddr_b = head_b;
    wdata_a = rdata_a;
    wdata_b = rdata_b;
    raddr_a = head_a;
    raddr_b = head_b;
    unique case (state)
      ST_IDLE: begin
        // first operand: top, or bottom for a reverse rotate
        if (s_tvalid) begin
          re_a    = 1'b1;
          re_b    = 1'b1;
          raddr_a = in_op_a.rot_dn ? bot_a : head_a;
          raddr_b = in_op_b.rot_dn ? bot_b : head_b;
        end
      end
      ST_RD1: begin
        // second entry for a swap
        re_a    = 1'b1;
        re_b    = 1'b1;
        raddr_a = inc_a;
        raddr_b = inc_b;
      end
      ST_WR0: begin
        if (op_a.swap && fill_a >= CW'(2)) begin
          we_a = 1'b1;
        end
        if (op_a.rot_up && fill_a != '0) begin
          we_a    = 1'b1;
          waddr_a = tail_a;
        end
        if (op_a.rot_dn && fill_a != '0) begin
          we_a    = 1'b1;
          waddr_a = dec_a;
        end
        if (cmd == F_PA && fill_b != '0) begin
          we_a    = 1'b1;
          waddr_a = dec_a;
          wdata_a = rdata_b;
        end
        if (cmd == F_LOAD && room) begin
          we_a    = 1'b1;
          waddr_a = tail_a;
          wdata_a = load_val;
        end
        if (op_b.swap && fill_b >= CW'(2)) begin
          we_b = 1'b1;
        end
        if (op_b.rot_up && fill_b != '0) begin
          we_b    = 1'b1;
          waddr_b = tail_b;
        end
        if (op_b.rot_dn && fill_b != '0) begin
          we_b    = 1'b1;
          waddr_b = dec_b;
        end
        if (cmd == F_PB && fill_a != '0) begin
          we_b    = 1'b1;
          waddr_b = dec_b;
          wdata_b = rdata_a;
        end
      end
      ST_WR1: begin
        // old top goes one down
        we_a    = op_a.swap && fill_a >= CW'(2);
        we_b    = op_b.swap && fill_b >= CW'(2);
        waddr_a = inc_a;
        waddr_b = inc_b;
        wdata_a = d0_a;
        wdata_b = d0_b;
      end
      ST_TOP: begin
        re_a = 1'b1;
        re_b = 1'b1;
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, pointers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head_a   <= '0;
      head_b   <= '0;
      fill_a   <= '0;
      fill_b   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // result taken; ST_OUT refills the register itself
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd      <= in_func;
            load_val <= s_tdata[FUNC_W +: WORD_W];
            state    <= (in_op_a.swap || in_op_b.swap) ? ST_RD1 : ST_WR0;
          end
        end
        ST_RD1: begin
          d0_a  <= rdata_a;
          d0_b  <= rdata_b;
          state <= ST_WR0;
        end
        ST_WR0: begin
          if (op_a.rot_up && fill_a != '0) head_a <= inc_a;
          if (op_a.rot_dn && fill_a != '0) head_a <= dec_a;
          if (op_b.rot_up && fill_b != '0) head_b <= inc_b;
          if (op_b.rot_dn && fill_b != '0) head_b <= dec_b;
          unique case (cmd)
            F_LOAD: begin
              perf <= room;
              rej  <= !room;
              if (room) begin
                fill_a <= fill_a + CW'(1);
              end
            end
            F_PA: begin
              perf <= (fill_b != '0);
              rej  <= 1'b0;
              if (fill_b != '0) begin
                head_a <= dec_a;
                fill_a <= fill_a + CW'(1);
                head_b <= inc_b;
                fill_b <= fill_b - CW'(1);
              end
            end
            F_PB: begin
              perf <= (fill_a != '0);
              rej  <= 1'b0;
              if (fill_a != '0) begin
                head_b <= dec_b;
                fill_b <= fill_b + CW'(1);
                head_a <= inc_a;
                fill_a <= fill_a - CW'(1);
              end
            end
            F_CLEAR: begin
              perf   <= 1'b1;
              rej    <= 1'b0;
              head_a <= '0;
              head_b <= '0;
              fill_a <= '0;
              fill_b <= '0;
            end
            F_SA, F_SB, F_SS, F_RA, F_RB, F_RR, F_RRA, F_RRB, F_RRR: begin
              perf <= 1'b1;
              rej  <= 1'b0;
            end
            default: begin
              perf <= 1'b0;
              rej  <= 1'b0;
            end
          endcase
          state <= (op_a.swap || op_b.swap) ? ST_WR1 : ST_TOP;
        end
        ST_WR1: begin
          state <= ST_TOP;
        end
        ST_TOP: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          // tops arrive from the memories; wait for a free result register
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            out_perf  <= perf;
            out_rej   <= rej;
            out_cnt_a <= COUNT_W'(fill_a);
            out_cnt_b <= COUNT_W'(fill_b);
            out_top_a <= (fill_a != '0) ? rdata_a : '0;
            out_top_b <= (fill_b != '0) ? rdata_b : '0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Stack memories
  dsspr_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .re    (re_a),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  dsspr_ram #(.WIDTH(WORD_W), .DEPTH(CAPACITY)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (wdata_b),
    .re    (re_b),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

endmodule

/* sv/dsspr_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds one stack of the engine; no package dependencies.
module dsspr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/dsspr_chk.sv */
// Port checker for the two-stack engine, bound to the top level.
// Depends on dsspr_pkg for the stream widths.
module dsspr_chk #(
  parameter int CAPACITY = 512
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [dsspr_pkg::M_DATA_W-1:0] m_tdata
);

  import dsspr_pkg::*;

  logic [COUNT_W:0] cnt_sum;
  logic             small_cap;

  assign cnt_sum   = {1'b0, m_tdata[11:2]} + {1'b0, m_tdata[21:12]};
  assign small_cap = (CAPACITY < 1024);

  // a refused load is never reported as performed
  a_rej_not_perf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[0])
    else $error("rejected_full together with performed");

  // both stacks together never exceed capacity (checked when CAPACITY is below 1024)
  a_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && small_cap |-> cnt_sum <= (COUNT_W + 1)'(CAPACITY))
    else $error("counts exceed capacity");

  // an empty stack A shows a zero top (checked when CAPACITY is below 1024)
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && small_cap && m_tdata[11:2] == '0 |-> m_tdata[53:22] == '0)
    else $error("empty stack A with non-zero top");

  // one command at a time: ready drops after an accept
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in flight");

  // a pending result is held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

endmodule

bind dual_stack_swap_push_rotate_engine dsspr_chk #(.CAPACITY(CAPACITY)) u_chk (.*);
